// ----- design/crg_pkg.sv -----
package crg_pkg;

	localparam int CURL_W  = 17;
	localparam int DELTA_W = 20;
	localparam int RATE_W  = 23;
	localparam int TIME_W  = 24;
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;

	// products of the cross multiplication
	localparam int LHS_W  = CURL_W + DELTA_W;
	localparam int PROD_W = RATE_W + DELTA_W;

	localparam logic [DELTA_W-1:0] US_PER_SEC        = DELTA_W'(1000000);
	localparam logic [RATE_W-1:0]  MAX_RATE_FLOOR    = RATE_W'(6554);
	localparam logic [RATE_W-1:0]  STABLE_RATE_FLOOR = RATE_W'(3277);
	localparam logic [TIME_W-1:0]  TIME_MAX          = {TIME_W{1'b1}};

	localparam logic [RATE_W-1:0]  MAX_RATE_RST     = RATE_W'(524288);
	localparam logic [RATE_W-1:0]  STABLE_RATE_RST  = RATE_W'(98304);
	localparam logic [TIME_W-1:0]  RECOVER_TIME_RST = TIME_W'(250000);

	// register indexes, word address paddr[3:2]
	localparam logic [1:0] REG_MAX_RATE     = 2'd0;
	localparam logic [1:0] REG_STABLE_RATE  = 2'd1;
	localparam logic [1:0] REG_RECOVER_TIME = 2'd2;

	typedef struct packed {
		logic [CURL_W-1:0]  mean_curl;
		logic               tracked;
		logic [DELTA_W-1:0] delta_us;
	} in_item_t;

	typedef struct packed {
		logic hold;
		logic in_recovery;
	} out_item_t;

	typedef struct packed {
		logic [RATE_W-1:0] max_rate;
		logic [RATE_W-1:0] stable_rate;
		logic [TIME_W-1:0] recover_time;
	} cfg_t;

	typedef struct packed {
		logic [CURL_W-1:0] last_curl;
		logic              have_last;
		logic              recovering;
		logic [TIME_W-1:0] stable_time;
	} gate_state_t;

endpackage

// ----- design/crg_cfg.sv -----
module crg_cfg import crg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_rate     <= MAX_RATE_RST;
			cfg_q.stable_rate  <= STABLE_RATE_RST;
			cfg_q.recover_time <= RECOVER_TIME_RST;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_MAX_RATE:     cfg_q.max_rate     <= pwdata[RATE_W-1:0];
				REG_STABLE_RATE:  cfg_q.stable_rate  <= pwdata[RATE_W-1:0];
				REG_RECOVER_TIME: cfg_q.recover_time <= pwdata[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_MAX_RATE:     prdata = DATA_W'(cfg_q.max_rate);
			REG_STABLE_RATE:  prdata = DATA_W'(cfg_q.stable_rate);
			REG_RECOVER_TIME: prdata = DATA_W'(cfg_q.recover_time);
			default:          prdata = '0;
		endcase
	end

endmodule

// ----- design/crg_core.sv -----
module crg_core import crg_pkg::*; (
	input  in_item_t    item,
	input  cfg_t        cfg,
	input  gate_state_t state,
	output gate_state_t state_nxt,
	output out_item_t   result
);

	logic [CURL_W-1:0]  diff;
	logic [LHS_W-1:0]   lhs;
	logic [RATE_W-1:0]  mr;
	logic [RATE_W-1:0]  sr;
	logic [PROD_W-1:0]  max_prod;
	logic [PROD_W-1:0]  stable_prod;
	logic               rate_zero;
	logic               above_max;
	logic               above_stable;
	logic [TIME_W:0]    sum;
	logic [TIME_W-1:0]  sum_sat;
	logic               hold;

	always_comb begin
		diff = (item.mean_curl >= state.last_curl) ? item.mean_curl - state.last_curl
			: state.last_curl - item.mean_curl;
		lhs  = LHS_W'(diff) * LHS_W'(US_PER_SEC);
		mr   = (cfg.max_rate < MAX_RATE_FLOOR) ? MAX_RATE_FLOOR : cfg.max_rate;
		sr   = (cfg.stable_rate < STABLE_RATE_FLOOR) ? STABLE_RATE_FLOOR : cfg.stable_rate;
		max_prod    = PROD_W'(mr) * PROD_W'(item.delta_us);
		stable_prod = PROD_W'(sr) * PROD_W'(item.delta_us);
		rate_zero    = !state.have_last || (item.delta_us == '0);
		above_max    = !rate_zero && (PROD_W'(lhs) > max_prod);
		above_stable = !rate_zero && (PROD_W'(lhs) > stable_prod);
		sum     = (TIME_W+1)'(state.stable_time) + (TIME_W+1)'(item.delta_us);
		sum_sat = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];

		state_nxt           = state;
		state_nxt.last_curl = item.mean_curl;
		state_nxt.have_last = 1'b1;
		hold                = 1'b0;

		if (!item.tracked) begin
			state_nxt.recovering  = 1'b1;
			state_nxt.stable_time = '0;
			hold                  = 1'b1;
		end else if (!state.have_last) begin
			hold = 1'b0;
		end else if (above_max) begin
			state_nxt.recovering  = 1'b1;
			state_nxt.stable_time = '0;
			hold                  = 1'b1;
		end else if (state.recovering) begin
			hold = 1'b1;
			if (!above_stable) begin
				state_nxt.stable_time = sum_sat;
				if (sum_sat >= cfg.recover_time) begin
					state_nxt.recovering  = 1'b0;
					state_nxt.stable_time = '0;
					hold                  = 1'b0;
				end
			end else begin
				state_nxt.stable_time = '0;
			end
		end

		result.hold        = hold;
		result.in_recovery = state_nxt.recovering;
	end

endmodule

// ----- design/curl_rate_glitch_gate.sv -----
// Curl rate glitch gate. Each item is one tracking frame (mean curl in Q1.16,
// tracked flag, elapsed microseconds); each item yields exactly one result
// item: hold (keep the last pose) and in_recovery (gate state after the frame).
// Untracked frames, or a curl change faster than max_rate, enter recovery;
// recovery ends once frames at or below stable_rate have summed recover_time
// microseconds. Rates are compared by cross multiplication, no division.
// Throughput is one item per clock while out_stall is low: an input register
// feeds a single pass of compare logic (three multipliers of at most 23x20
// bits) into a result register, and the gate state updates as each item moves
// into that register. A stalled result holds the staged item, which then raises
// in_stall. Registers are written over the APB port at byte addresses 0, 4 and
// 8; the user must write them only while idle, and the block does not enforce it.
module curl_rate_glitch_gate import crg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// frame input channel
	input  logic              in_valid,
	output logic              in_stall,
	input  in_item_t          in_data,
	// result channel
	output logic              out_valid,
	input  logic              out_stall,
	output out_item_t         out_data,
	// configuration port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	cfg_t        cfg;
	logic        v_s1;
	in_item_t    item_s1;
	logic        out_valid_q;
	out_item_t   result_q;
	gate_state_t state_q;
	gate_state_t state_nxt;
	out_item_t   result_nxt;
	logic        advance;
	logic        in_take;

	crg_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	crg_core u_core (
		.item      (item_s1),
		.cfg       (cfg),
		.state     (state_q),
		.state_nxt (state_nxt),
		.result    (result_nxt)
	);

	// the staged item moves on whenever the result register is free or draining
	assign advance  = v_s1 && (!out_valid_q || !out_stall);
	// input register only stalls while its item is stuck behind the result
	assign in_stall = v_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	assign out_valid = out_valid_q;
	assign out_data  = result_q;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_take) begin
			v_s1 <= 1'b1;
		end else if (advance) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1 <= in_data;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_nxt;
		end
	end

	// gate state commits together with the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// an accepted frame never leaves the gate in recovery
	a_release_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !result_q.hold |-> !result_q.in_recovery)
		else $error("result accepts a frame while still in recovery");

	// outside recovery no stable time is carried
	a_idle_time_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!state_q.recovering |-> state_q.stable_time == '0)
		else $error("stable time nonzero outside recovery");

	// a blocked staged item holds its place and contents
	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && out_valid_q && out_stall |=> v_s1 && $stable(item_s1))
		else $error("staged item lost while result is stalled");

	// the result register reports what the state register committed
	a_state_match: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> result_q.in_recovery == state_q.recovering)
		else $error("result recovery flag disagrees with gate state");

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top import crg_pkg::*;;

	// watchdog limit: cycles with no item moving on either channel
	localparam int IDLE_LIMIT = 2000;
	localparam int NDIR       = 20;
	localparam int NPHASE     = 5;

	// directed frame with an optional hand-written verdict
	typedef struct packed {
		logic [CURL_W-1:0]  curl;
		logic               trk;
		logic [DELTA_W-1:0] delta;
		logic               known;
		logic               hold;
		logic               rec;
	} dir_row_t;

	// directed frames, run with the reset register values
	localparam dir_row_t DIR_TAB [NDIR] = '{
		// first tracked sample passes
		'{17'd65536,  1'b1, 20'd0,       1'b1, 1'b0, 1'b0},
		// no change over a normal frame
		'{17'd65536,  1'b1, 20'd11111,   1'b1, 1'b0, 1'b0},
		// zero elapsed time means zero rate, even for a full swing
		'{17'd0,      1'b1, 20'd0,       1'b1, 1'b0, 1'b0},
		// full swing in one microsecond trips the collapse limit
		'{17'd65536,  1'b1, 20'd1,       1'b1, 1'b1, 1'b1},
		// untracked, all-ones curl and time
		'{17'd131071, 1'b0, 20'd1048575, 1'b1, 1'b1, 1'b1},
		// one long still frame is enough to release
		'{17'd131071, 1'b1, 20'd1048575, 1'b1, 1'b0, 1'b0},
		'{17'd0,      1'b1, 20'd1048575, 1'b0, 1'b0, 1'b0},
		// untracked with zero time
		'{17'd0,      1'b0, 20'd0,       1'b1, 1'b1, 1'b1},
		// stable time builds, then a mid-rate frame clears it
		'{17'd1000,   1'b1, 20'd100000,  1'b0, 1'b0, 1'b0},
		'{17'd6000,   1'b1, 20'd20000,   1'b0, 1'b0, 1'b0},
		'{17'd6000,   1'b1, 20'd100000,  1'b0, 1'b0, 1'b0},
		'{17'd6000,   1'b1, 20'd100000,  1'b0, 1'b0, 1'b0},
		'{17'd6000,   1'b1, 20'd100000,  1'b0, 1'b0, 1'b0},
		// alternating bit patterns on curl and time
		'{17'h15555,  1'b1, 20'hAAAAA,   1'b0, 1'b0, 1'b0},
		'{17'h0AAAA,  1'b1, 20'h55555,   1'b0, 1'b0, 1'b0},
		'{17'd65536,  1'b1, 20'd0,       1'b0, 1'b0, 1'b0},
		'{17'd0,      1'b1, 20'd1,       1'b1, 1'b1, 1'b1},
		'{17'd0,      1'b1, 20'd1048575, 1'b1, 1'b0, 1'b0},
		'{17'd131071, 1'b1, 20'd1,       1'b1, 1'b1, 1'b1},
		'{17'd131071, 1'b0, 20'd1,       1'b1, 1'b1, 1'b1}
	};

	// register settings of the later phases; the last phase is drawn at random
	localparam cfg_t PHASE_CFG [3] = '{
		'{23'd0, 23'd0, 24'd0},
		'{23'd6553600, 23'd6553600, 24'd10000000},
		'{23'h7FFFFF, 23'd3276, 24'hFFFFFF}
	};
	localparam int PHASE_ITEMS [NPHASE] = '{300, 200, 200, 150, 350};

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	in_item_t          in_data;
	logic              out_valid;
	logic              out_stall;
	out_item_t         out_data;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	// predictor copy of the gate registers and state
	cfg_t              cfg = '{MAX_RATE_RST, STABLE_RATE_RST, RECOVER_TIME_RST};
	logic [CURL_W-1:0] g_last_curl = '0;
	logic              g_have_last = 1'b0;
	logic              g_recovering = 1'b0;
	logic [TIME_W-1:0] g_stable_time = '0;

	out_item_t         verdict_q[$];
	int                error_count = 0;
	int                gen_curl = 0;
	logic              no_gaps = 1'b0;
	logic              in_go = 1'b0;
	logic              out_go = 1'b0;
	int                idle_cycles;
	int                stall_mode = 0;
	int                stall_burst = 0;

	curl_rate_glitch_gate u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// 10 ns clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// verdict for one frame; advances the predictor state
	function automatic out_item_t gate_verdict(in_item_t f);
		logic [63:0]       diff;
		logic [63:0]       lhs;
		logic [RATE_W-1:0] mr;
		logic [RATE_W-1:0] sr;
		logic              first;
		logic              rate_zero;
		logic              too_fast;
		logic              unsteady;
		logic [TIME_W:0]   sum;
		out_item_t         r;
		first     = !g_have_last;
		rate_zero = first || (f.delta_us == '0);
		diff = (f.mean_curl >= g_last_curl) ? 64'(f.mean_curl) - 64'(g_last_curl)
			: 64'(g_last_curl) - 64'(f.mean_curl);
		mr = (cfg.max_rate < MAX_RATE_FLOOR) ? MAX_RATE_FLOOR : cfg.max_rate;
		sr = (cfg.stable_rate < STABLE_RATE_FLOOR) ? STABLE_RATE_FLOOR : cfg.stable_rate;
		// rate compare by cross multiplication, no division
		lhs      = diff * 64'(US_PER_SEC);
		too_fast = !rate_zero && (lhs > 64'(mr) * 64'(f.delta_us));
		unsteady = !rate_zero && (lhs > 64'(sr) * 64'(f.delta_us));
		g_last_curl = f.mean_curl;
		g_have_last = 1'b1;
		r.hold = 1'b0;
		if (!f.tracked) begin
			g_recovering  = 1'b1;
			g_stable_time = '0;
			r.hold        = 1'b1;
		end else if (first) begin
			r.hold = 1'b0;
		end else if (too_fast) begin
			g_recovering  = 1'b1;
			g_stable_time = '0;
			r.hold        = 1'b1;
		end else if (g_recovering) begin
			r.hold = 1'b1;
			if (!unsteady) begin
				// saturating stable-time sum
				sum = {1'b0, g_stable_time} + (TIME_W+1)'(f.delta_us);
				g_stable_time = (sum > {1'b0, TIME_MAX}) ? TIME_MAX : sum[TIME_W-1:0];
				if (g_stable_time >= cfg.recover_time) begin
					g_recovering  = 1'b0;
					g_stable_time = '0;
					r.hold        = 1'b0;
				end
			end else begin
				g_stable_time = '0;
			end
		end
		r.in_recovery = g_recovering;
		return r;
	endfunction

	// random frame: mostly smooth tracking, with glitches, dropouts and noise
	function automatic in_item_t make_frame();
		in_item_t f;
		int       pick;
		int       step;
		int       nc;
		longint   lim;
		longint   sr;
		pick = $urandom_range(99);
		sr = (cfg.stable_rate < STABLE_RATE_FLOOR) ? STABLE_RATE_FLOOR : cfg.stable_rate;
		f.tracked  = 1'b1;
		f.delta_us = DELTA_W'($urandom_range(16000, 8000));
		nc = gen_curl;
		if (pick < 3) begin
			// raw noise over the full field widths
			f.mean_curl = CURL_W'($urandom);
			f.tracked   = 1'($urandom);
			f.delta_us  = DELTA_W'($urandom);
			gen_curl    = int'(f.mean_curl);
			return f;
		end
		if (pick < 7) begin
			// tracking dropout
			f.tracked = 1'b0;
		end else if (pick < 9) begin
			// repeated timestamp with a jump
			f.delta_us = '0;
			nc = $urandom_range(65536);
		end else if (pick < 13) begin
			// glitch: jump anywhere
			nc = $urandom_range(65536);
		end else begin
			if (pick < 17)
				f.delta_us = DELTA_W'($urandom_range(1048575, 500000));
			// step sized against the stable rate, mostly below it
			lim = sr * longint'(f.delta_us) / 1000000;
			if ($urandom_range(9) == 0)
				step = $urandom_range(int'(3 * lim + 1), int'(lim));
			else
				step = $urandom_range(int'(lim));
			nc = $urandom_range(1) ? nc + step : nc - step;
		end
		if (nc < 0)
			nc = 0;
		if (nc > 65536)
			nc = 65536;
		f.mean_curl = CURL_W'(nc);
		gen_curl    = nc;
		return f;
	endfunction

	// offer one item after a random gap; predict it once accepted
	task automatic push_frame(in_item_t f, logic known, out_item_t want);
		int   gap;
		int   r;
		logic go;
		out_item_t pred;
		if ($urandom_range(39) == 0)
			no_gaps = !no_gaps;
		r = $urandom_range(99);
		if (no_gaps || r < 55)
			gap = 0;
		else if (r < 85)
			gap = $urandom_range(3, 1);
		else if (r < 97)
			gap = $urandom_range(10, 4);
		else
			gap = $urandom_range(60, 20);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= f;
		// stall is stable by the falling edge; sample there
		do begin
			@(negedge clk);
			go = !in_stall;
			@(posedge clk);
		end while (!go);
		pred = gate_verdict(f);
		verdict_q.push_back(known ? want : pred);
	endtask

	// wait until every result is back, then let the pipeline settle
	task automatic settle();
		in_valid <= 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// register write, then read back
	task automatic reg_write(logic [1:0] idx, logic [DATA_W-1:0] val);
		logic [DATA_W-1:0] got;
		logic [DATA_W-1:0] mask;
		mask = (idx == REG_RECOVER_TIME) ? (DATA_W'(1) << TIME_W) - 1
			: (DATA_W'(1) << RATE_W) - 1;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		// register takes the value at this edge; go on to the read setup
		@(posedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		got = prdata;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if ((got & mask) !== (val & mask)) begin
			$error("register %0d readback: expected %0h, got %0h", idx, val & mask, got & mask);
			error_count++;
		end
		case (idx)
			REG_MAX_RATE:     cfg.max_rate     = val[RATE_W-1:0];
			REG_STABLE_RATE:  cfg.stable_rate  = val[RATE_W-1:0];
			REG_RECOVER_TIME: cfg.recover_time = val[TIME_W-1:0];
			default: ;
		endcase
	endtask

	// result stall: modes of none, light and heavy, with rare long bursts
	always @(posedge clk) begin
		if (stall_burst != 0) begin
			out_stall   <= 1'b1;
			stall_burst <= stall_burst - 1;
		end else begin
			if ($urandom_range(49) == 0)
				stall_mode <= $urandom_range(2);
			case (stall_mode)
				0:       out_stall <= 1'b0;
				1:       out_stall <= ($urandom_range(9) == 0);
				default: out_stall <= ($urandom_range(1) == 0);
			endcase
			if ($urandom_range(199) == 0)
				stall_burst <= $urandom_range(50, 20);
		end
	end

	// handshakes sampled mid-cycle; a result seen here is taken at the next edge
	always @(negedge clk) begin
		out_item_t want;
		in_go  = arst_n && in_valid && !in_stall;
		out_go = arst_n && out_valid && !out_stall;
		if (out_go) begin
			if (verdict_q.size() == 0) begin
				$error("result item with nothing expected: hold %0b in_recovery %0b",
					out_data.hold, out_data.in_recovery);
				error_count++;
			end else begin
				want = verdict_q.pop_front();
				if (out_data.hold !== want.hold) begin
					$error("hold: expected %0b, got %0b", want.hold, out_data.hold);
					error_count++;
				end
				if (out_data.in_recovery !== want.in_recovery) begin
					$error("in_recovery: expected %0b, got %0b",
						want.in_recovery, out_data.in_recovery);
					error_count++;
				end
			end
		end
	end

	// watchdog on cycles where nothing moves
	initial begin
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if (in_go || out_go)
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Test completed with failures");
		$finish;
	end

	// main sequence
	initial begin
		dir_row_t  row;
		in_item_t  f;
		out_item_t want;
		cfg_t      next;
		int        n;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		out_stall = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frames at reset register values
		for (int k = 0; k < NDIR; k++) begin
			row = DIR_TAB[k];
			f.mean_curl      = row.curl;
			f.tracked        = row.trk;
			f.delta_us       = row.delta;
			want.hold        = row.hold;
			want.in_recovery = row.rec;
			push_frame(f, row.known, want);
		end
		gen_curl = 0;

		for (int ph = 0; ph < NPHASE; ph++) begin
			settle();
			// phase 0 keeps the reset values
			if (ph > 0) begin
				if (ph <= 3) begin
					next = PHASE_CFG[ph-1];
				end else begin
					next.max_rate     = RATE_W'($urandom_range(6553600));
					next.stable_rate  = RATE_W'($urandom_range(400000));
					next.recover_time = TIME_W'($urandom_range(400000));
				end
				reg_write(REG_MAX_RATE, DATA_W'(next.max_rate));
				reg_write(REG_STABLE_RATE, DATA_W'(next.stable_rate));
				reg_write(REG_RECOVER_TIME, DATA_W'(next.recover_time));
			end
			// all-ones recovery time: still frames drive the stable time into saturation
			if (ph == 3) begin
				for (int k = 0; k < 18; k++) begin
					f.mean_curl = 17'd30000;
					f.tracked   = (k != 0);
					f.delta_us  = (k == 0) ? '0 : {DELTA_W{1'b1}};
					push_frame(f, 1'b0, '0);
				end
				gen_curl = 30000;
			end
			n = PHASE_ITEMS[ph];
			for (int i = 0; i < n; i++) begin
				// sender holds off mid-phase until every result is back
				if (i == n / 2)
					settle();
				push_frame(make_frame(), 1'b0, '0);
			end
		end

		settle();
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ----- filelist.f -----
design/crg_pkg.sv
design/crg_cfg.sv
design/crg_core.sv
design/curl_rate_glitch_gate.sv
dv/tb_top.sv
